// ===== src/tpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Tachometer period average: shared types and constants
// Holds the divider width, the rpm numerator, the state encoding and the
// command word that the top level hands to the serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

    // Field widths fixed by the interface.
    localparam int TS_W     = 32;
    localparam int SMP_W    = 10;
    localparam int PERIOD_W = 16;
    localparam int RPM_W    = 26;

    // Serial divider: 26-bit dividend/quotient, 16-bit divisor.
    localparam int DIV_W     = 26;
    localparam int DVR_W     = 16;
    localparam int DIV_CNT_W = 5;

    localparam logic [RPM_W-1:0]    RPM_NUMERATOR = 26'd60000000;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX    = 16'hFFFF;
    localparam logic [SMP_W-1:0]    THRESH_RESET  = 10'd512;

    // Input command codes.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_AVG,
        ST_RPM,
        ST_DONE
    } tpa_state_t;

    // Start request for the serial divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] iters;
    } div_cmd_t;

endpackage

`default_nettype wire

// ===== src/tachometer_period_average.sv =====
// ----------------------------------------------------------------------------
// Tachometer period average
// Detects beam breaks in photodiode samples, keeps a ring of the last
// SAMPLES periods with a running sum, and reports the average period,
// the speed in rpm and the peak speed once the ring is full.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake             Word
//  s_*       in         s_tvalid / s_tready   tuser = cmd, tdata = time, sample
//  m_*       out        m_tvalid / m_tready   tdata = marked .. peak_rpm
//  cfg_*     in         cfg_valid / cfg_ready cfg_data = threshold
//
//  A clear command, or a sample while the ring is not full, passes from
//  acceptance through the update and done steps to the result register.
//  With the ring full, the serial divider forms one quotient bit per cycle,
//  first for sum / SAMPLES, then, if the average is not zero, for
//  60000000 / average. A new word is taken while a result waits in the
//  output register; a result that cannot leave holds the block in its last
//  step. Reset is synchronous and active low; the ring needs no clearing.
//
`default_nettype none

module tachometer_period_average #(
    parameter int SAMPLES = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    input  wire logic [47:0] s_tdata,   // [31:0] timestamp_us, [41:32] sample, [47:42] zero
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // [0] marked, [1] full_res, [17:2] avg_period,
                                        // [43:18] speed_rpm, [69:44] peak_rpm, [71:70] zero
    // Threshold register write.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [9:0]  cfg_data
);

    import tpa_pkg::*;

    localparam int IDX_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int CNT_W     = $clog2(SAMPLES + 1);
    localparam int SUM_W     = PERIOD_W + $clog2(SAMPLES);
    localparam int SUM_SHIFT = DIV_W - SUM_W;

    // Control state.
    tpa_state_t         state_reg, state_next;
    logic [SMP_W-1:0]   threshold_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [TS_W-1:0]    last_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [IDX_W-1:0]   wi_reg;
    logic [RPM_W-1:0]   best_reg;
    logic               m_tvalid_reg;

    // Latched input word and per-item results.
    logic               cmd_reg;
    logic [TS_W-1:0]    ts_reg;
    logic [SMP_W-1:0]   smp_reg;
    logic               marked_reg;
    logic               full_reg;
    logic [PERIOD_W-1:0] avg_reg;
    logic [RPM_W-1:0]   speed_reg;
    logic [71:0]        m_tdata_reg;

    // Period ring.
    logic [PERIOD_W-1:0] ring_mem [SAMPLES];
    logic [PERIOD_W-1:0] old_reg;

    // Update datapath.
    logic                mark;
    logic [TS_W-1:0]     diff;
    logic [PERIOD_W-1:0] period;
    logic                full_now;
    logic                full_next;
    logic [SUM_W-1:0]    sum_next;
    logic [CNT_W-1:0]    fill_next;
    logic [IDX_W-1:0]    wi_next;
    logic [RPM_W-1:0]    best_next;

    // Handshake and divider control.
    logic                in_accept;
    logic                out_load;
    div_cmd_t            div_cmd;
    logic [DIV_W-1:0]    div_dividend;
    logic [DVR_W-1:0]    div_divisor;
    logic                div_done;
    logic [DIV_W-1:0]    div_quot;

    assign in_accept = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Mark detection and ring/sum update for the latched word.
    always_comb begin
        mark     = (smp_reg <= threshold_reg) && (ts_reg != last_reg);
        diff     = ts_reg - last_reg;
        period   = (diff[TS_W-1:PERIOD_W] != '0) ? PERIOD_MAX : diff[PERIOD_W-1:0];
        full_now = (fill_reg == CNT_W'(SAMPLES));
        if (mark) begin
            full_next = full_now || (fill_reg == CNT_W'(SAMPLES - 1));
            fill_next = full_now ? fill_reg : fill_reg + CNT_W'(1);
            sum_next  = sum_reg - (full_now ? SUM_W'(old_reg) : '0) + SUM_W'(period);
            wi_next   = (wi_reg == IDX_W'(SAMPLES - 1)) ? '0 : wi_reg + IDX_W'(1);
        end else begin
            full_next = full_now;
            fill_next = fill_reg;
            sum_next  = sum_reg;
            wi_next   = wi_reg;
        end
        best_next = (speed_reg > best_reg) ? speed_reg : best_reg;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (cmd_reg == CMD_CLEAR || !full_next) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                if (div_done) begin
                    state_next = (div_quot[PERIOD_W-1:0] == '0) ? ST_DONE : ST_RPM;
                end
            end
            ST_RPM: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine: input ready and divider requests.
    always_comb begin
        s_tready      = 1'b0;
        div_cmd.start = 1'b0;
        div_cmd.iters = DIV_CNT_W'(SUM_W);
        div_dividend  = DIV_W'(sum_next) << SUM_SHIFT;
        div_divisor   = DVR_W'(SAMPLES);
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_UPDATE: begin
                div_cmd.start = (cmd_reg == CMD_SAMPLE) && full_next;
            end
            ST_AVG: begin
                div_cmd.start = div_done && (div_quot[PERIOD_W-1:0] != '0);
                div_cmd.iters = DIV_CNT_W'(DIV_W);
                div_dividend  = DIV_W'(RPM_NUMERATOR);
                div_divisor   = div_quot[PERIOD_W-1:0];
            end
            ST_RPM, ST_DONE: begin
                s_tready = 1'b0;
            end
            default: s_tready = 1'b0;
        endcase
    end

    tpa_div_serial u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_in   (div_cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Control registers: state, threshold, ring bookkeeping, peak, valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            threshold_reg <= THRESH_RESET;
            sum_reg       <= '0;
            last_reg      <= '0;
            fill_reg      <= '0;
            wi_reg        <= '0;
            best_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                threshold_reg <= cfg_data;
            end
            if (state_reg == ST_UPDATE) begin
                if (cmd_reg == CMD_CLEAR) begin
                    sum_reg  <= '0;
                    last_reg <= '0;
                    fill_reg <= '0;
                    wi_reg   <= '0;
                    best_reg <= '0;
                end else if (mark) begin
                    sum_reg  <= sum_next;
                    last_reg <= ts_reg;
                    fill_reg <= fill_next;
                    wi_reg   <= wi_next;
                end
            end
            if (out_load) begin
                best_reg     <= best_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: input word, per-item results, output word.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            cmd_reg <= s_tuser[0];
            ts_reg  <= s_tdata[TS_W-1:0];
            smp_reg <= s_tdata[TS_W+SMP_W-1:TS_W];
        end
        if (state_reg == ST_UPDATE) begin
            marked_reg <= (cmd_reg == CMD_SAMPLE) && mark;
            full_reg   <= (cmd_reg == CMD_SAMPLE) && full_next;
            avg_reg    <= '0;
            speed_reg  <= '0;
        end
        if (state_reg == ST_AVG && div_done) begin
            avg_reg <= div_quot[PERIOD_W-1:0];
        end
        if (state_reg == ST_RPM && div_done) begin
            speed_reg <= div_quot[RPM_W-1:0];
        end
        if (out_load) begin
            m_tdata_reg <= {2'b00, best_next, speed_reg, avg_reg, full_reg, marked_reg};
        end
    end

    // Period ring: written on a mark, read every cycle at the write index.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPDATE && cmd_reg == CMD_SAMPLE && mark) begin
            ring_mem[wi_reg] <= period;
        end
        old_reg <= ring_mem[wi_reg];
    end

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== src/tpa_div_serial.sv =====
// ----------------------------------------------------------------------------
// Tachometer period average: bit-serial restoring divider
// Produces one quotient bit per cycle. The dividend is loaded left aligned
// in a shift register; after cmd_in.iters steps the low bits of that
// register hold the quotient. done pulses for one cycle at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_div_serial (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire tpa_pkg::div_cmd_t         cmd_in,
    input  wire logic [tpa_pkg::DIV_W-1:0] dividend,
    input  wire logic [tpa_pkg::DVR_W-1:0] divisor,
    output logic                           done,
    output logic [tpa_pkg::DIV_W-1:0]      quotient
);

    import tpa_pkg::*;

    logic [DIV_W-1:0]     work_reg;
    logic [DVR_W-1:0]     rem_reg;
    logic [DVR_W-1:0]     dvr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DVR_W:0]       rem_shift;
    logic                 q_bit;
    logic [DVR_W-1:0]     rem_next;
    logic [DIV_W-1:0]     work_next;

    // One restoring step: shift in the next dividend bit, try a subtract.
    always_comb begin
        rem_shift = {rem_reg, work_reg[DIV_W-1]};
        q_bit     = (rem_shift >= {1'b0, dvr_reg});
        rem_next  = q_bit ? DVR_W'(rem_shift - {1'b0, dvr_reg}) : rem_shift[DVR_W-1:0];
        work_next = {work_reg[DIV_W-2:0], q_bit};
    end

    // Control: step counter, busy and done flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == DIV_CNT_W'(1));
            if (cmd_in.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= cmd_in.iters;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: partial remainder and dividend/quotient shift register.
    always_ff @(posedge aclk) begin
        if (cmd_in.start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            dvr_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tachometer_period_average_tb.sv =====
// ----------------------------------------------------------------------------
// Tachometer period average: self-checking testbench
// Sends sample and clear words into the block, predicts each result from a
// model of the period ring, and compares every returned word field by field.
// The run is a short directed sequence followed by random phases with
// different thresholds, with bursty input traffic and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tachometer_period_average_tb;

    import tpa_pkg::*;

    localparam int RING_DEPTH    = 8;
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS   = 175;

    // One result word, lowest field in the lowest bits.
    typedef struct packed {
        logic [1:0]          pad;
        logic [RPM_W-1:0]    peak_rpm;
        logic [RPM_W-1:0]    speed_rpm;
        logic [PERIOD_W-1:0] avg_period;
        logic                full_res;
        logic                marked;
    } tach_result_t;

    // Predicts the speed results and keeps the ones still owed by the block.
    class tach_scoreboard;
        logic [SMP_W-1:0]    threshold;
        logic [PERIOD_W-1:0] period_ring [RING_DEPTH];
        int unsigned         period_sum;
        logic [TS_W-1:0]     last_mark;
        int unsigned         fill_count;
        int unsigned         wr_slot;
        logic [RPM_W-1:0]    best_rpm;
        tach_result_t        owed_q [$];
        int unsigned         errors;

        function new();
            threshold = THRESH_RESET;
            errors    = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            foreach (period_ring[i]) period_ring[i] = '0;
            period_sum = 0;
            last_mark  = '0;
            fill_count = 0;
            wr_slot    = 0;
            best_rpm   = '0;
        endfunction

        // Applies one accepted input word and queues the result it causes.
        function void note_input(logic cmd, logic [TS_W-1:0] stamp, logic [SMP_W-1:0] smp);
            tach_result_t        res;
            logic [TS_W-1:0]     diff;
            logic [PERIOD_W-1:0] period;
            int unsigned         avg;

            res = '0;
            if (cmd == CMD_CLEAR) begin
                clear_ring();
                owed_q.push_back(res);
                return;
            end

            // A break records the wrapped, saturated time since the last mark.
            if (smp <= threshold && stamp != last_mark) begin
                diff   = stamp - last_mark;
                period = (diff > TS_W'(PERIOD_MAX)) ? PERIOD_MAX : diff[PERIOD_W-1:0];
                if (fill_count >= RING_DEPTH)
                    period_sum -= period_ring[wr_slot];
                else
                    fill_count++;
                period_ring[wr_slot] = period;
                period_sum += period;
                last_mark  = stamp;
                wr_slot    = (wr_slot + 1) % RING_DEPTH;
                res.marked = 1'b1;
            end

            if (fill_count >= RING_DEPTH) begin
                avg = period_sum / RING_DEPTH;
                if (avg > PERIOD_MAX)
                    avg = PERIOD_MAX;
                res.full_res   = 1'b1;
                res.avg_period = avg[PERIOD_W-1:0];
                if (avg != 0)
                    res.speed_rpm = RPM_W'(int'(RPM_NUMERATOR) / avg);
            end

            if (res.speed_rpm > best_rpm)
                best_rpm = res.speed_rpm;
            res.peak_rpm = best_rpm;
            owed_q.push_back(res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted result word against the oldest prediction.
        function void check_result(logic [71:0] word);
            tach_result_t got;
            tach_result_t want;

            got = word;
            if (owed_q.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, word);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("marked", want.marked, got.marked);
            compare_field("full_res", want.full_res, got.full_res);
            compare_field("avg_period", want.avg_period, got.avg_period);
            compare_field("speed_rpm", want.speed_rpm, got.speed_rpm);
            compare_field("peak_rpm", want.peak_rpm, got.peak_rpm);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [0:0]        s_tuser   = '0;  // [0] cmd
    logic [47:0]       s_tdata   = '0;  // [31:0] timestamp_us, [41:32] sample, [47:42] zero
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [71:0]       m_tdata;         // [0] marked, [1] full_res, [17:2] avg_period,
                                        // [43:18] speed_rpm, [69:44] peak_rpm, [71:70] zero
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SMP_W-1:0]  cfg_data  = '0;

    tach_scoreboard    sb = new();

    int unsigned       burst_left = 0;
    int unsigned       rx_mode    = 0;
    int unsigned       rx_left    = 0;

    tachometer_period_average #(
        .SAMPLES(RING_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard limit on the run time.
    initial begin
        #(64'd25_000_000);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: check accepted words, then pick the next ready pattern.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        if (rx_left == 0) begin
            rx_mode = $urandom_range(3, 0);
            case (rx_mode)
                0:       rx_left = $urandom_range(200, 20);
                1:       rx_left = $urandom_range(40, 1);
                default: rx_left = $urandom_range(60, 10);
            endcase
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'b0;
            default: m_tready <= 1'($urandom_range(1, 0));
        endcase
    end

    // Sends one word, with a random gap at the start of each burst.
    task automatic send_word(input logic cmd, input logic [TS_W-1:0] stamp,
                             input logic [SMP_W-1:0] smp);
        int unsigned gap;

        if (burst_left == 0) begin
            if ($urandom_range(4, 0) == 0) begin
                burst_left = $urandom_range(150, 50);
                gap        = 0;
            end else begin
                burst_left = $urandom_range(30, 1);
                gap        = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
            end
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, smp, stamp};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, stamp, smp);
    endtask

    // Stops sending and waits until the block has returned every result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the threshold register; only called while the block is idle.
    task automatic write_threshold(input logic [SMP_W-1:0] level);
        cfg_valid <= 1'b1;
        cfg_data  <= level;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.threshold = level;
    endtask

    // Random traffic: mostly rotating-disk words around a base period.
    task automatic run_random_phase(input int n_words);
        int unsigned      base;
        int unsigned      pick;
        logic [TS_W-1:0]  ts_now;
        logic [TS_W-1:0]  stamp;
        logic [SMP_W-1:0] smp;
        logic [SMP_W-1:0] thr;
        logic             cmd;

        thr = sb.threshold;
        case ($urandom_range(3, 0))
            0:       base = $urandom_range(16, 1);
            1:       base = $urandom_range(5000, 200);
            2:       base = $urandom_range(70000, 20000);
            default: base = $urandom_range(200000, 60000);
        endcase
        ts_now = $urandom;
        for (int i = 0; i < n_words; i++) begin
            pick = $urandom_range(99, 0);
            cmd  = CMD_SAMPLE;
            if (pick < 2) begin
                cmd   = CMD_CLEAR;
                stamp = $urandom;
                smp   = $urandom_range(1023, 0);
            end else if (pick < 6) begin
                // A break at the time of the last mark must be ignored.
                stamp = sb.last_mark;
                smp   = $urandom_range(thr, 0);
            end else if (pick < 11) begin
                stamp = $urandom;
                smp   = $urandom_range(1023, 0);
            end else begin
                ts_now += $urandom_range(base, 1);
                stamp  = ts_now;
                if ($urandom_range(9, 0) < 7 || thr == 10'd1023)
                    smp = $urandom_range(thr, 0);
                else
                    smp = $urandom_range(1023, thr + 1);
            end
            send_word(cmd, stamp, smp);
        end
        drain();
    endtask

    // Main sequence.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: the reset threshold and the ring edge cases.
        write_threshold(THRESH_RESET);
        send_word(CMD_SAMPLE, 32'd100, 10'd513);        // just above threshold
        send_word(CMD_SAMPLE, 32'd0, 10'd0);            // same time as reset mark
        send_word(CMD_SAMPLE, 32'd1, 10'd512);          // at threshold, first mark
        send_word(CMD_SAMPLE, 32'd1, 10'd0);            // repeated timestamp
        for (int k = 2; k <= 8; k++)
            send_word(CMD_SAMPLE, TS_W'(k), SMP_W'($urandom_range(512, 0)));
        send_word(CMD_SAMPLE, 32'd9, 10'd1023);         // full ring, no break
        send_word(CMD_SAMPLE, 32'h0002_0000, 10'd0);    // long period saturates
        send_word(CMD_SAMPLE, 32'hFFFF_FFFF, 10'd0);
        send_word(CMD_SAMPLE, 32'h0000_0005, 10'd0);    // timestamp wraps
        send_word(CMD_CLEAR, 32'hFFFF_FFFF, 10'd1023);
        send_word(CMD_SAMPLE, 32'd0, 10'd0);            // repeated after clear
        drain();

        // Directed: lowest threshold, every period saturated.
        write_threshold(10'd0);
        for (int k = 1; k <= 8; k++)
            send_word(CMD_SAMPLE, TS_W'(k * 70000), 10'd0);
        send_word(CMD_SAMPLE, TS_W'(8 * 70000 + 5), 10'd1);
        drain();

        // Random phases over a spread of thresholds, extremes first.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       write_threshold(10'd1023);
                1:       write_threshold(10'd0);
                2:       write_threshold(THRESH_RESET);
                default: write_threshold(SMP_W'($urandom_range(1023, 0)));
            endcase
            run_random_phase(PHASE_WORDS);
        end

        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/tpa_pkg.sv
src/tpa_div_serial.sv
src/tachometer_period_average.sv
tb/sv/tachometer_period_average_tb.sv
